[src/assert_macros.svh]
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, prop)
`endif
`endif

[src/ppr_pkg.sv]
package ppr_pkg;
  localparam int unsigned MaxPoints = 256;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_BUILD    = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_SUM      = 3'd3,
    REQ_GET      = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_REVERSED = 3'd2,
    ST_FULL     = 3'd3,
    ST_PHASE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] x_low;
    logic signed [31:0] y_low;
    logic signed [31:0] x_high;
    logic signed [31:0] y_high;
    logic signed [31:0] amount;
  } in_t;

  typedef struct packed {
    logic signed [63:0] total;
    logic [2:0]         status;
  } out_t;
endpackage

[src/planar_point_range_sum.sv]
// every request scans all stored points, one per cycle, through a single
// compare-and-accumulate unit; a successful register or add then passes through a write
// state, and a build clears every stored weight
// throughput: one beat at a time; in_ready_o stays low until the output beat is taken
// reset: asynchronous active-low; clears point count, build flag, fsm and output valid
// the point memory is not cleared
`include "assert_macros.svh"
module planar_point_range_sum #(
  parameter int unsigned MAX_POINTS = ppr_pkg::MaxPoints
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ppr_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ppr_pkg::out_t out_data_o
);
  import ppr_pkg::*;

  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_LAST  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [63:0] mem_w [MAX_POINTS];

  in_t               req_q;
  logic [CntW-1:0]   cnt_q;
  logic              built_q;
  logic [CntW-1:0]   idx_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [31:0]       rx_q, ry_q;
  logic [63:0]       rw_q;
  logic              found_q;
  logic [IdxW-1:0]   hit_q;
  logic [63:0]       acc_q;
  out_t              out_q;
  logic              out_vld_q;

  assign in_ready_o  = (state_q == S_IDLE) && !out_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  logic eq_pt, in_rng;
  always_comb begin
    eq_pt  = (rx_q == req_q.x_low) && (ry_q == req_q.y_low);
    in_rng = ($signed(rx_q) >= req_q.x_low) && ($signed(rx_q) < req_q.x_high) &&
             ($signed(ry_q) >= req_q.y_low) && ($signed(ry_q) < req_q.y_high);
  end

  logic [IdxW-1:0] wr_idx;
  assign wr_idx = (req_q.req_type == REQ_REGISTER) ? cnt_q[IdxW-1:0] : hit_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && idx_q < cnt_q) begin
      rx_q <= mem_x[idx_q[IdxW-1:0]];
      ry_q <= mem_y[idx_q[IdxW-1:0]];
      rw_q <= mem_w[idx_q[IdxW-1:0]];
    end
    if (state_q == S_CLEAR && idx_q < cnt_q) begin
      mem_w[idx_q[IdxW-1:0]] <= '0;
    end
    if (state_q == S_WRITE) begin
      if (req_q.req_type == REQ_REGISTER) begin
        mem_x[wr_idx] <= req_q.x_low;
        mem_y[wr_idx] <= req_q.y_low;
      end else begin
        mem_w[wr_idx] <= acc_q;
      end
    end
  end

  logic scan_end;
  assign scan_end = (idx_q >= cnt_q);

  logic [63:0] amt_ext;
  status_e     wait_status;
  logic [63:0] wait_total;
  state_e      wait_next;

  assign amt_ext = {{32{req_q.amount[31]}}, req_q.amount};

  always_comb begin
    wait_next   = S_OUT;
    wait_status = ST_OK;
    wait_total  = '0;
    unique case (req_q.req_type)
      REQ_REGISTER: begin
        if (built_q) wait_status = ST_PHASE;
        else if (!found_q) begin
          if (cnt_q >= CntW'(MAX_POINTS)) wait_status = ST_FULL;
          else wait_next = S_WRITE;
        end
      end
      REQ_BUILD: begin
        if (built_q) wait_status = ST_PHASE;
        else wait_next = S_CLEAR;
      end
      REQ_ADD: begin
        if (!built_q) wait_status = ST_PHASE;
        else if (!found_q) wait_status = ST_UNKNOWN;
        else wait_next = S_WRITE;
      end
      REQ_SUM: begin
        if (!built_q) wait_status = ST_PHASE;
        else if (req_q.x_low > req_q.x_high || req_q.y_low > req_q.y_high)
          wait_status = ST_REVERSED;
        else wait_total = acc_q;
      end
      REQ_GET: begin
        if (!built_q) wait_status = ST_PHASE;
        else if (found_q) wait_total = acc_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_LAST;
      S_LAST:  state_d = S_WAIT;
      S_WAIT:  state_d = wait_next;
      S_WRITE: state_d = S_OUT;
      S_CLEAR: if (scan_end) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      built_q   <= 1'b0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      req_q     <= '0;
      rd_idx_q  <= '0;
      hit_q     <= '0;
      acc_q     <= '0;
      out_q     <= '0;
    end else begin
      if (state_q == S_OUT) out_vld_q <= 1'b1;
      else if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      rd_vld_q <= (state_q == S_SCAN) && !scan_end;
      rd_idx_q <= idx_q[IdxW-1:0];
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q   <= in_data_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            acc_q   <= '0;
          end
        end
        S_SCAN: begin
          if (!scan_end) idx_q <= idx_q + 1'b1;
        end
        S_LAST: ;
        S_WAIT: begin
          out_q.total  <= wait_total;
          out_q.status <= wait_status;
          if (wait_next == S_CLEAR) idx_q <= '0;
          if (wait_next == S_WRITE && req_q.req_type == REQ_ADD) acc_q <= acc_q + amt_ext;
        end
        S_WRITE: begin
          if (req_q.req_type == REQ_REGISTER) cnt_q <= cnt_q + 1'b1;
        end
        S_CLEAR: begin
          if (!scan_end) idx_q <= idx_q + 1'b1;
          else built_q <= 1'b1;
        end
        S_OUT: ;
        default: ;
      endcase
      if (rd_vld_q) begin
        if (req_q.req_type == REQ_SUM) begin
          if (in_rng) acc_q <= acc_q + rw_q;
        end else if (eq_pt && !found_q) begin
          found_q <= 1'b1;
          hit_q   <= rd_idx_q;
          acc_q   <= rw_q;
        end
      end
      state_q <= state_d;
    end
  end

  `ASSERT_NEVER(a_busy_no_ready, (state_q != S_IDLE) && in_ready_o)
  `ASSERT_IMPL(a_out_after, (state_q == S_OUT) |=> out_vld_q)
  `ASSERT_NEVER(a_cnt_range, cnt_q > CntW'(MAX_POINTS))
  `ASSERT_IMPL(a_built_stays, built_q |=> built_q)
endmodule
